FILE: rtl/crcan_pkg.sv
// Shared types and codes for the circle raster canvas unit.
package crcan_pkg;

    localparam int IN_TDATA_W  = 88;
    localparam int OUT_TDATA_W = 16;
    localparam int CFG_DATA_W  = 9;
    localparam int CFG_INDEX_W = 2;
    localparam int COORD_W     = 20;
    localparam int DIM_W       = 9;
    localparam int PIX_W       = 8;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_DRAW  = 2'd1,
        OP_READ  = 2'd2,
        OP_NONE  = 2'd3
    } opcode_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_WIDTH      = 2'd0,
        CFG_HEIGHT     = 2'd1,
        CFG_BACKGROUND = 2'd2,
        CFG_UNUSED     = 2'd3
    } cfg_index_t;

    localparam logic STATUS_DONE     = 1'b0;
    localparam logic STATUS_REJECTED = 1'b1;

    localparam logic [DIM_W-1:0] WIDTH_RESET      = 9'd256;
    localparam logic [DIM_W-1:0] HEIGHT_RESET     = 9'd256;
    localparam logic [PIX_W-1:0] BACKGROUND_RESET = 8'd32;

    // input item, opcode in the lowest bits
    typedef struct packed {
        logic        [PIX_W-1:0]   pixel_y;
        logic        [PIX_W-1:0]   pixel_x;
        logic        [PIX_W-1:0]   color;
        logic signed [COORD_W-1:0] radius;
        logic signed [COORD_W-1:0] center_y;
        logic signed [COORD_W-1:0] center_x;
        logic                      filled;
        logic        [1:0]         opcode;
    } in_item_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_value;
        logic             status;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_SETUP,
        ST_DRAW,
        ST_CLEAR,
        ST_READ,
        ST_READ_WAIT,
        ST_DONE
    } state_t;

endpackage

FILE: rtl/circle_raster_canvas_unit.sv
// Circle raster canvas: character canvas in one memory with clear, draw circle and read pixel.
//
// An item is taken only while the unit is idle; a finished result sits in the output
// register, so the next item can be taken before the result is collected. Clear and draw
// circle walk the W*H pixels of the active area (W, H the active width and height, capped
// at MAX_SIDE); read pixel passes a read and a read-wait state; a rejected draw or an empty
// area goes straight to done. The canvas walk visits one pixel per cycle and writes through
// the single write port of the canvas memory; the squared distance of each pixel is updated
// by additions only, from squares formed once per draw. Reset does not clear the canvas.
module circle_raster_canvas_unit #(
    parameter int MAX_SIDE  = 256,
    parameter int FRAC_BITS = 8
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // opcode, filled, center_x, center_y, radius, color, pixel_x, pixel_y, zero pad
    input  logic [crcan_pkg::IN_TDATA_W-1:0]      s_tdata,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // status, pixel_value, zero pad
    output logic [crcan_pkg::OUT_TDATA_W-1:0]     m_tdata,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    input  logic                                  cfg_we,
    input  logic [crcan_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [crcan_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

    localparam int XW    = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
    localparam int EW    = $clog2(MAX_SIDE + 1);
    localparam int DEPTH = MAX_SIDE * MAX_SIDE;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PW    = XW + FRAC_BITS + 1;
    localparam int DW    = ((PW > crcan_pkg::COORD_W) ? PW : crcan_pkg::COORD_W) + 1;
    localparam int SQW   = 2 * DW;
    localparam int CW    = crcan_pkg::COORD_W;
    localparam int PXW   = crcan_pkg::PIX_W;

    localparam logic signed [SQW-1:0] ONE_SQ     = SQW'(1) << (2 * FRAC_BITS);
    localparam logic signed [SQW-1:0] TWO_ONE_SQ = SQW'(1) << (2 * FRAC_BITS + 1);
    localparam logic signed [CW:0]    ONE_FX     = (CW + 1)'(1) << FRAC_BITS;

    crcan_pkg::in_item_t in_item;
    crcan_pkg::state_t   state_reg, state_next;

    // configuration
    logic [crcan_pkg::DIM_W-1:0] cfg_width_reg, cfg_height_reg;
    logic [PXW-1:0]              background_reg;

    // latched item
    logic                 filled_reg;
    logic signed [CW-1:0] cx_reg, cy_reg, r_reg;
    logic [PXW-1:0]       color_reg, px_reg, py_reg;

    // walk
    logic [EW-1:0] w_eff, h_eff, w_eff_reg, h_eff_reg;
    logic [XW-1:0] x_reg, y_reg;
    logic [AW-1:0] addr_reg, rowaddr_reg;
    logic          last_col, last_row;

    // distance datapath
    logic signed [2*CW-1:0]   cx_sq, cy_sq, r_sq;
    logic signed [2*CW+1:0]   rm1_sq;
    logic signed [CW:0]       rm1;
    logic signed [SQW-1:0]    cx_sq_reg, cy_sq_reg, r_sq_reg, inner_sq_reg;
    logic signed [SQW-1:0]    d2_reg, rowbase_reg, sx_reg, sx0_reg, sy_reg;
    logic signed [SQW-1:0]    cx_ext, cy_ext;
    logic                     use_inner_reg, hit;

    // canvas memory
    logic [PXW-1:0] canvas_mem [DEPTH];
    logic           mem_we, rd_en, in_range;
    logic [PXW-1:0] mem_wdata, rd_data_reg;
    logic [AW-1:0]  rd_addr;

    // result
    logic           res_status_reg;
    logic [PXW-1:0] res_pix_reg;
    logic           m_tvalid_reg, m_status_reg, out_load;
    logic [PXW-1:0] m_pix_reg;
    logic           accept;

    crcan_pkg::out_item_t out_item;

    assign in_item = crcan_pkg::in_item_t'(s_tdata[$bits(crcan_pkg::in_item_t)-1:0]);
    assign accept  = s_tvalid && s_tready;

    assign w_eff = (32'(cfg_width_reg) > MAX_SIDE) ? EW'(MAX_SIDE) : EW'(cfg_width_reg);
    assign h_eff = (32'(cfg_height_reg) > MAX_SIDE) ? EW'(MAX_SIDE) : EW'(cfg_height_reg);

    assign last_col = (EW'(x_reg) == w_eff_reg - EW'(1));
    assign last_row = (EW'(y_reg) == h_eff_reg - EW'(1));

    assign cx_sq  = cx_reg * cx_reg;
    assign cy_sq  = cy_reg * cy_reg;
    assign r_sq   = r_reg * r_reg;
    assign rm1    = (CW + 1)'(r_reg) - ONE_FX;
    assign rm1_sq = rm1 * rm1;
    assign cx_ext = SQW'(cx_reg);
    assign cy_ext = SQW'(cy_reg);

    assign hit = (d2_reg <= r_sq_reg) && (!use_inner_reg || (d2_reg > inner_sq_reg));

    assign in_range = (32'(px_reg) < MAX_SIDE) && (32'(py_reg) < MAX_SIDE);
    assign rd_addr  = AW'(32'(py_reg) * MAX_SIDE + 32'(px_reg));

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_width_reg  <= crcan_pkg::WIDTH_RESET;
            cfg_height_reg <= crcan_pkg::HEIGHT_RESET;
            background_reg <= crcan_pkg::BACKGROUND_RESET;
        end else if (cfg_we) begin
            case (crcan_pkg::cfg_index_t'(cfg_index))
                crcan_pkg::CFG_WIDTH:      cfg_width_reg  <= cfg_wdata;
                crcan_pkg::CFG_HEIGHT:     cfg_height_reg <= cfg_wdata;
                crcan_pkg::CFG_BACKGROUND: background_reg <= cfg_wdata[PXW-1:0];
                default: ;
            endcase
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            crcan_pkg::ST_IDLE: begin
                if (accept) begin
                    case (crcan_pkg::opcode_t'(in_item.opcode))
                        crcan_pkg::OP_CLEAR:
                            state_next = (w_eff == '0 || h_eff == '0) ?
                                         crcan_pkg::ST_DONE : crcan_pkg::ST_CLEAR;
                        crcan_pkg::OP_DRAW:
                            state_next = (in_item.radius <= 0 || w_eff == '0 ||
                                          h_eff == '0) ?
                                         crcan_pkg::ST_DONE : crcan_pkg::ST_SQUARE;
                        crcan_pkg::OP_READ: state_next = crcan_pkg::ST_READ;
                        default:            state_next = crcan_pkg::ST_DONE;
                    endcase
                end
            end
            crcan_pkg::ST_SQUARE:    state_next = crcan_pkg::ST_SETUP;
            crcan_pkg::ST_SETUP:     state_next = crcan_pkg::ST_DRAW;
            crcan_pkg::ST_DRAW,
            crcan_pkg::ST_CLEAR: begin
                if (last_col && last_row) begin
                    state_next = crcan_pkg::ST_DONE;
                end
            end
            crcan_pkg::ST_READ:      state_next = crcan_pkg::ST_READ_WAIT;
            crcan_pkg::ST_READ_WAIT: state_next = crcan_pkg::ST_DONE;
            crcan_pkg::ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    state_next = crcan_pkg::ST_IDLE;
                end
            end
            default:                 state_next = crcan_pkg::ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        s_tready  = 1'b0;
        mem_we    = 1'b0;
        mem_wdata = color_reg;
        rd_en     = 1'b0;
        out_load  = 1'b0;
        case (state_reg)
            crcan_pkg::ST_IDLE:  s_tready = 1'b1;
            crcan_pkg::ST_DRAW:  mem_we = hit;
            crcan_pkg::ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_wdata = background_reg;
            end
            crcan_pkg::ST_READ:  rd_en = in_range;
            crcan_pkg::ST_DONE:  out_load = !m_tvalid_reg || m_tready;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= crcan_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // canvas memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            canvas_mem[addr_reg] <= mem_wdata;
        end
        if (rd_en) begin
            rd_data_reg <= canvas_mem[rd_addr];
        end
    end

    // item latch, walk counters and distance tracking
    always_ff @(posedge aclk) begin
        case (state_reg)
            crcan_pkg::ST_IDLE: begin
                if (accept) begin
                    filled_reg     <= in_item.filled;
                    cx_reg         <= in_item.center_x;
                    cy_reg         <= in_item.center_y;
                    r_reg          <= in_item.radius;
                    color_reg      <= in_item.color;
                    px_reg         <= in_item.pixel_x;
                    py_reg         <= in_item.pixel_y;
                    w_eff_reg      <= w_eff;
                    h_eff_reg      <= h_eff;
                    x_reg          <= '0;
                    y_reg          <= '0;
                    addr_reg       <= '0;
                    rowaddr_reg    <= '0;
                    res_pix_reg    <= '0;
                    res_status_reg <= (crcan_pkg::opcode_t'(in_item.opcode) ==
                                       crcan_pkg::OP_DRAW && in_item.radius <= 0) ?
                                      crcan_pkg::STATUS_REJECTED : crcan_pkg::STATUS_DONE;
                end
            end
            crcan_pkg::ST_SQUARE: begin
                cx_sq_reg     <= SQW'(cx_sq);
                cy_sq_reg     <= SQW'(cy_sq);
                r_sq_reg      <= SQW'(r_sq);
                inner_sq_reg  <= SQW'(rm1_sq);
                use_inner_reg <= !filled_reg && (rm1 >= 0);
            end
            crcan_pkg::ST_SETUP: begin
                d2_reg      <= cx_sq_reg + cy_sq_reg;
                rowbase_reg <= cx_sq_reg + cy_sq_reg;
                sx0_reg     <= ONE_SQ - (cx_ext <<< (FRAC_BITS + 1));
                sx_reg      <= ONE_SQ - (cx_ext <<< (FRAC_BITS + 1));
                sy_reg      <= ONE_SQ - (cy_ext <<< (FRAC_BITS + 1));
            end
            crcan_pkg::ST_DRAW,
            crcan_pkg::ST_CLEAR: begin
                if (!last_col) begin
                    x_reg    <= x_reg + XW'(1);
                    addr_reg <= addr_reg + AW'(1);
                    d2_reg   <= d2_reg + sx_reg;
                    sx_reg   <= sx_reg + TWO_ONE_SQ;
                end else if (!last_row) begin
                    // advance to the start of the next row
                    x_reg       <= '0;
                    y_reg       <= y_reg + XW'(1);
                    rowaddr_reg <= rowaddr_reg + AW'(MAX_SIDE);
                    addr_reg    <= rowaddr_reg + AW'(MAX_SIDE);
                    d2_reg      <= rowbase_reg + sy_reg;
                    rowbase_reg <= rowbase_reg + sy_reg;
                    sy_reg      <= sy_reg + TWO_ONE_SQ;
                    sx_reg      <= sx0_reg;
                end
            end
            crcan_pkg::ST_READ_WAIT: begin
                res_pix_reg <= in_range ? rd_data_reg : '0;
            end
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_status_reg <= res_status_reg;
            m_pix_reg    <= res_pix_reg;
        end
    end

    assign out_item.status      = m_status_reg;
    assign out_item.pixel_value = m_pix_reg;
    assign m_tdata  = crcan_pkg::OUT_TDATA_W'(out_item);
    assign m_tvalid = m_tvalid_reg;

    // memory is written only while walking the canvas
    assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> (state_reg == crcan_pkg::ST_DRAW || state_reg == crcan_pkg::ST_CLEAR))
        else $error("canvas write outside a walk");

    // a result appears only after the done state loaded it
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == crcan_pkg::ST_DONE))
        else $error("result shown without completion");

    // an accepted item always leaves idle
    assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> state_reg != crcan_pkg::ST_IDLE)
        else $error("accepted item dropped");

    // walk stays inside the active area
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == crcan_pkg::ST_DRAW || state_reg == crcan_pkg::ST_CLEAR) |->
        (EW'(x_reg) < w_eff_reg && EW'(y_reg) < h_eff_reg))
        else $error("walk left the active area");

endmodule
